/* rtl/idr_pkg.sv */
// Shared codes, field widths and control structs for the id registry block.
package idr_pkg;

  // Field widths fixed by the request and result formats
  localparam int ACTION_W   = 2;
  localparam int ID_W       = 17;
  localparam int TASK_W     = 17;
  localparam int AGE_W      = 8;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 4;
  localparam int COUNT_W    = 5;

  // Request action codes
  localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SWEEP  = 2'd2;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LISTED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  // Update status codes
  localparam logic [STATUS_W-1:0] UPD_EXISTING = 2'd0;
  localparam logic [STATUS_W-1:0] UPD_NEW      = 2'd1;
  localparam logic [STATUS_W-1:0] UPD_FULL     = 2'd2;

  // Constants
  localparam logic [AGE_W-1:0]  AGE_MAX         = 8'hFF;
  localparam logic [AGE_W-1:0]  TIMEOUT_DEFAULT = 8'd30;
  localparam logic [TASK_W-1:0] TASK_IDLE       = 17'h1FFFF;

  // Commands from controller to datapath
  typedef struct packed {
    logic upd_cap;    // register compare vectors and request payload
    logic age_all;    // age every valid slot
    logic upd_apply;  // write the selected slot and post the update status
    logic swp_init;   // clear scan index and counters
    logic swp_drop;   // free the current slot as stale
    logic swp_list;   // post the current slot as a listing
    logic swp_adv;    // advance the scan index
    logic sum_emit;   // post the sweep summary
  } idr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic cur_valid;  // slot under the scan index is valid
    logic cur_stale;  // slot under the scan index is past the timeout
    logic idx_last;   // scan index is at the final slot
  } idr_sts_t;

endpackage

/* rtl/idr_in_if.sv */
// Request channel: valid/ready handshake carrying one registry request.
interface idr_in_if;
  logic                             valid;
  logic                             ready;
  logic [idr_pkg::ACTION_W-1:0]     action;
  logic [idr_pkg::ID_W-1:0]         client_id;
  logic signed [idr_pkg::TASK_W-1:0] task_number;

  modport source (output valid, output action, output client_id, output task_number,
                  input ready);
  modport sink   (input valid, input action, input client_id, input task_number,
                  output ready);
endinterface

/* rtl/idr_out_if.sv */
// Result channel: valid/ready handshake carrying one registry result.
interface idr_out_if;
  logic                                valid;
  logic                                ready;
  logic [idr_pkg::KIND_W-1:0]          kind;
  logic [idr_pkg::STATUS_W-1:0]        update_status;
  logic [idr_pkg::SLOT_IDX_W-1:0]      slot_index;
  logic [idr_pkg::ID_W-1:0]            listed_id;
  logic signed [idr_pkg::TASK_W-1:0]   listed_task;
  logic                                busy_res;
  logic [idr_pkg::COUNT_W-1:0]         active_count;
  logic [idr_pkg::COUNT_W-1:0]         removed_count;
  logic                                last;

  modport source (output valid, output kind, output update_status, output slot_index,
                  output listed_id, output listed_task, output busy_res,
                  output active_count, output removed_count, output last,
                  input ready);
  modport sink   (input valid, input kind, input update_status, input slot_index,
                  input listed_id, input listed_task, input busy_res,
                  input active_count, input removed_count, input last,
                  output ready);
endinterface

/* rtl/id_registry_with_aging.sv */
// Top level of the client id registry with per-slot aging.
//
// A table of SLOTS client slots keyed by a 17-bit id. Requests arrive one at a time on
// in_ch and results leave on out_ch through an output register, so a new request is taken
// while the previous result still waits downstream. A tick gives no result. An update
// compares the id against every slot in parallel at acceptance, then writes the lowest
// matching or free slot and posts the status. A sweep scans the table one slot per cycle
// through a single read port, pausing on a surviving slot while out_ch stalls; it posts
// one listing per surviving slot and a closing summary. The user must write stale_timeout
// through cfg_wr_en and cfg_wr_data only while no request is in flight; the block itself
// does not enforce this. stale_timeout resets to 30.
module id_registry_with_aging #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  idr_in_if.sink                     in_ch,
  idr_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [idr_pkg::AGE_W-1:0]  cfg_wr_data
);

  idr_pkg::idr_cmd_t cmd;
  idr_pkg::idr_sts_t sts;
  logic              ready;

  assign in_ch.ready = ready;

  // Sequence requests
  idr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the table and the result register
  idr_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_client_id   (in_ch.client_id),
    .in_task_number (in_ch.task_number),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_ch         (out_ch)
  );

endmodule

/* rtl/idr_ctrl.sv */
// Controller: sequences update, tick and sweep requests over the datapath.
module idr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [idr_pkg::ACTION_W-1:0]  in_action,
  output logic                          in_ready,
  input  idr_pkg::idr_sts_t             sts,
  output idr_pkg::idr_cmd_t             cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SWEEP,
    ST_SUM
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            idr_pkg::ACT_UPDATE: begin
              cmd.upd_cap = 1'b1;
              state_nxt   = ST_APPLY;
            end
            idr_pkg::ACT_TICK: begin
              cmd.age_all = 1'b1;
            end
            idr_pkg::ACT_SWEEP: begin
              cmd.swp_init = 1'b1;
              state_nxt    = ST_SWEEP;
            end
            default: begin
              // unused action: drop the request
            end
          endcase
        end
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          cmd.upd_apply = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (!sts.cur_valid) begin
          cmd.swp_adv = 1'b1;
        end else if (sts.cur_stale) begin
          cmd.swp_drop = 1'b1;
          cmd.swp_adv  = 1'b1;
        end else if (sts.out_free) begin
          cmd.swp_list = 1'b1;
          cmd.swp_adv  = 1'b1;
        end
        if (cmd.swp_adv && sts.idx_last) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sts.out_free) begin
          cmd.sum_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/idr_dpath.sv */
// Datapath: slot table, parallel id compare, aging, sweep scan and result register.
module idr_dpath #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [idr_pkg::ID_W-1:0]          in_client_id,
  input  logic signed [idr_pkg::TASK_W-1:0] in_task_number,
  input  logic                              cfg_wr_en,
  input  logic [idr_pkg::AGE_W-1:0]         cfg_wr_data,
  input  idr_pkg::idr_cmd_t                 cmd,
  output idr_pkg::idr_sts_t                 sts,
  idr_out_if.source                         out_ch
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Slot table
  logic [SLOTS-1:0]                 valid_r;
  logic [idr_pkg::ID_W-1:0]         id_r   [SLOTS];
  logic [idr_pkg::TASK_W-1:0]       task_r [SLOTS];
  logic [idr_pkg::AGE_W-1:0]        age_r  [SLOTS];
  logic [idr_pkg::AGE_W-1:0]        timeout_r;

  // Update request capture
  logic [SLOTS-1:0]                 hit_r;
  logic [SLOTS-1:0]                 free_r;
  logic [idr_pkg::ID_W-1:0]         upd_id_r;
  logic [idr_pkg::TASK_W-1:0]       upd_task_r;

  // Sweep scan
  logic [IDX_W-1:0]                 idx_r;
  logic [CNT_W-1:0]                 act_cnt_r;
  logic [CNT_W-1:0]                 rem_cnt_r;

  // Result register
  logic                             out_valid_r;
  logic [idr_pkg::KIND_W-1:0]       kind_r;
  logic [idr_pkg::STATUS_W-1:0]     status_r;
  logic [idr_pkg::SLOT_IDX_W-1:0]   sidx_r;
  logic [idr_pkg::ID_W-1:0]         lid_r;
  logic [idr_pkg::TASK_W-1:0]       ltask_r;
  logic                             busy_r;
  logic [idr_pkg::COUNT_W-1:0]      act_out_r;
  logic [idr_pkg::COUNT_W-1:0]      rem_out_r;
  logic                             last_r;

  // Combinational selects
  logic                             hit_any;
  logic                             free_any;
  logic [IDX_W-1:0]                 hit_idx;
  logic [IDX_W-1:0]                 free_idx;
  logic [IDX_W-1:0]                 upd_idx;
  logic [IDX_W+idr_pkg::SLOT_IDX_W-1:0] sidx_ext;
  logic [CNT_W+idr_pkg::COUNT_W-1:0]    act_ext;
  logic [CNT_W+idr_pkg::COUNT_W-1:0]    rem_ext;
  logic                             out_load;

  // Pick lowest matching and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |hit_r;
  assign free_any = |free_r;
  assign upd_idx  = hit_any ? hit_idx : free_idx;

  // Status toward the controller
  assign sts.out_free  = !out_valid_r || out_ch.ready;
  assign sts.cur_valid = valid_r[idx_r];
  assign sts.cur_stale = age_r[idx_r] > timeout_r;
  assign sts.idx_last  = (idx_r == IDX_W'(SLOTS - 1));

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= idr_pkg::TIMEOUT_DEFAULT;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // Compare the request id against every valid slot at acceptance
  always_ff @(posedge clk) begin
    if (cmd.upd_cap) begin
      for (int i = 0; i < SLOTS; i++) begin
        hit_r[i]  <= valid_r[i] && (id_r[i] == in_client_id);
        free_r[i] <= !valid_r[i];
      end
      upd_id_r   <= in_client_id;
      upd_task_r <= in_task_number;
    end
  end

  // Slot valid bits: set on new entry, drop on stale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.upd_apply && !hit_any && free_any) begin
      valid_r[free_idx] <= 1'b1;
    end else if (cmd.swp_drop) begin
      valid_r[idx_r] <= 1'b0;
    end
  end

  // Slot payload: write on update, age on tick
  always_ff @(posedge clk) begin
    if (cmd.upd_apply && (hit_any || free_any)) begin
      id_r[upd_idx]   <= hit_any ? id_r[upd_idx] : upd_id_r;
      task_r[upd_idx] <= upd_task_r;
      age_r[upd_idx]  <= '0;
    end
    if (cmd.age_all) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (valid_r[i] && (age_r[i] != idr_pkg::AGE_MAX)) begin
          age_r[i] <= age_r[i] + 1'b1;
        end
      end
    end
  end

  // Advance the sweep scan and tally counts
  always_ff @(posedge clk) begin
    if (cmd.swp_init) begin
      idx_r     <= '0;
      act_cnt_r <= '0;
      rem_cnt_r <= '0;
    end else begin
      if (cmd.swp_adv) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.swp_drop) begin
        rem_cnt_r <= rem_cnt_r + 1'b1;
      end
      if (cmd.swp_list) begin
        act_cnt_r <= act_cnt_r + 1'b1;
      end
    end
  end

  // Fit indexes and counts to the result field widths; a full table selects slot 0
  always_comb begin
    sidx_ext = '0;
    if (cmd.upd_apply) begin
      sidx_ext = {{idr_pkg::SLOT_IDX_W{1'b0}}, upd_idx};
    end else if (cmd.swp_list) begin
      sidx_ext = {{idr_pkg::SLOT_IDX_W{1'b0}}, idx_r};
    end
    act_ext = {{idr_pkg::COUNT_W{1'b0}}, act_cnt_r};
    rem_ext = {{idr_pkg::COUNT_W{1'b0}}, rem_cnt_r};
  end

  assign out_load = cmd.upd_apply || cmd.swp_list || cmd.sum_emit;

  // Output valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r    <= idr_pkg::KIND_UPDATE;
      status_r  <= idr_pkg::UPD_EXISTING;
      sidx_r    <= sidx_ext[idr_pkg::SLOT_IDX_W-1:0];
      lid_r     <= '0;
      ltask_r   <= '0;
      busy_r    <= 1'b0;
      act_out_r <= '0;
      rem_out_r <= '0;
      last_r    <= 1'b0;
      if (cmd.upd_apply) begin
        last_r <= 1'b1;
        if (hit_any) begin
          status_r <= idr_pkg::UPD_EXISTING;
        end else if (free_any) begin
          status_r <= idr_pkg::UPD_NEW;
        end else begin
          status_r <= idr_pkg::UPD_FULL;
        end
      end else if (cmd.swp_list) begin
        kind_r  <= idr_pkg::KIND_LISTED;
        lid_r   <= id_r[idx_r];
        ltask_r <= task_r[idx_r];
        busy_r  <= (task_r[idx_r] != idr_pkg::TASK_IDLE);
      end else begin
        kind_r    <= idr_pkg::KIND_SUMMARY;
        act_out_r <= act_ext[idr_pkg::COUNT_W-1:0];
        rem_out_r <= rem_ext[idr_pkg::COUNT_W-1:0];
        last_r    <= 1'b1;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.update_status = status_r;
  assign out_ch.slot_index    = sidx_r;
  assign out_ch.listed_id     = lid_r;
  assign out_ch.listed_task   = ltask_r;
  assign out_ch.busy_res      = busy_r;
  assign out_ch.active_count  = act_out_r;
  assign out_ch.removed_count = rem_out_r;
  assign out_ch.last          = last_r;

  // Identifiers stay unique among valid slots, so at most one slot matches
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_apply |-> $onehot0(hit_r))
    else $error("update matched more than one slot");

  // Only a valid slot is dropped or listed by the sweep
  a_sweep_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.swp_drop || cmd.swp_list) |-> valid_r[idx_r])
    else $error("sweep acted on a free slot");

  // Listed and removed slots never exceed the table
  a_sweep_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_emit |-> (({1'b0, act_cnt_r} + {1'b0, rem_cnt_r}) <= (CNT_W + 1)'(SLOTS)))
    else $error("sweep counts exceed slot count");

endmodule
